// File: hw/rtl/cpfc_pkg.sv
// Shared types and constants for the camera parallel frame capture block.
package cpfc_pkg;

    localparam int unsigned MAX_COLUMNS = 640;
    localparam int unsigned MAX_ROWS    = 480;

    localparam int unsigned COL_W  = 10;
    localparam int unsigned ROW_W  = 9;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_CAPTURE_CHROMA = 2'd0,
        REG_FRAME_WIDTH    = 2'd1,
        REG_FRAME_HEIGHT   = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_HIGH = 2'd1,
        PH_WAIT_LOW  = 2'd2,
        PH_CAPTURE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic             capture_chroma;
        logic [COL_W-1:0] frame_width;
        logic [ROW_W-1:0] frame_height;
    } t_cfg;

endpackage

// File: hw/rtl/cpfc_if.sv
// Valid/ready channel interfaces for pin-sample requests and capture results.
interface cpfc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic       vsync_level;
    logic       pclk_level;
    logic [7:0] pixel_byte;

    modport source (output valid, command, vsync_level, pclk_level, pixel_byte,
                    input ready);
    modport sink   (input valid, command, vsync_level, pclk_level, pixel_byte,
                    output ready);
endinterface

interface cpfc_out_if;
    logic       valid;
    logic       ready;
    logic       pixel_valid;
    logic [7:0] pixel_value;
    logic [8:0] pixel_row;
    logic [9:0] pixel_column;
    logic       frame_done;
    logic       capture_busy;

    modport source (output valid, pixel_valid, pixel_value, pixel_row, pixel_column,
                    frame_done, capture_busy, input ready);
    modport sink   (input valid, pixel_valid, pixel_value, pixel_row, pixel_column,
                    frame_done, capture_busy, output ready);
endinterface

// File: hw/rtl/cpfc_regs.sv
// APB-style configuration register file for the frame capture block.
module cpfc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpfc_pkg::APB_AW-1:0]   paddr,
    input  logic [cpfc_pkg::APB_DW-1:0]   pwdata,
    output logic [cpfc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output cpfc_pkg::t_cfg                o_cfg
);
    import cpfc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign pready  = 1'b1;
    assign w_idx   = t_reg_idx'(paddr[3:2]);
    assign w_write = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write && paddr[1:0] == 2'b00) begin
            case (w_idx)
                REG_CAPTURE_CHROMA: n_cfg.capture_chroma = pwdata[0];
                REG_FRAME_WIDTH:    n_cfg.frame_width    = pwdata[COL_W-1:0];
                REG_FRAME_HEIGHT:   n_cfg.frame_height   = pwdata[ROW_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capture_chroma <= 1'b0;
            r_cfg.frame_width    <= COL_W'(320);
            r_cfg.frame_height   <= ROW_W'(240);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_CAPTURE_CHROMA: prdata = {{(APB_DW-1){1'b0}}, r_cfg.capture_chroma};
            REG_FRAME_WIDTH:    prdata = {{(APB_DW-COL_W){1'b0}}, r_cfg.frame_width};
            REG_FRAME_HEIGHT:   prdata = {{(APB_DW-ROW_W){1'b0}}, r_cfg.frame_height};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// File: hw/rtl/cpfc_core.sv
// Capture sequencer, pixel clock edge detector, counters and result register.
module cpfc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cpfc_pkg::t_cfg i_cfg,
    cpfc_in_if.sink        i_req,
    cpfc_out_if.source     o_res
);
    import cpfc_pkg::*;

    t_phase            r_phase, n_phase;
    logic              r_prev_pclk, n_prev_pclk;
    logic              r_second, n_second;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    logic              r_out_valid;
    logic              r_pix_valid, n_pix_valid;
    logic [BYTE_W-1:0] r_pix_value, n_pix_value;
    logic [ROW_W-1:0]  r_pix_row, n_pix_row;
    logic [COL_W-1:0]  r_pix_col, n_pix_col;
    logic              r_done, n_done;
    logic              r_busy, n_busy;

    logic              w_accept;
    logic [COL_W-1:0]  w_col_start;
    logic [ROW_W-1:0]  w_row_start;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Start values of the down counters, with the dimensions clamped to range.
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w_col_start = '0;
        end else if (i_cfg.frame_width > COL_W'(MAX_COLUMNS)) begin
            w_col_start = COL_W'(MAX_COLUMNS - 1);
        end else begin
            w_col_start = i_cfg.frame_width - COL_W'(1);
        end
        if (i_cfg.frame_height == '0) begin
            w_row_start = '0;
        end else if (i_cfg.frame_height > ROW_W'(MAX_ROWS)) begin
            w_row_start = ROW_W'(MAX_ROWS - 1);
        end else begin
            w_row_start = i_cfg.frame_height - ROW_W'(1);
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_prev_pclk = r_prev_pclk;
        n_second    = r_second;
        n_col       = r_col;
        n_row       = r_row;
        n_pix_valid = 1'b0;
        n_pix_value = '0;
        n_pix_row   = '0;
        n_pix_col   = '0;
        n_done      = 1'b0;
        if (w_accept) begin
            if (i_req.command) begin
                n_phase     = PH_WAIT_HIGH;
                n_prev_pclk = 1'b1;
                n_second    = 1'b0;
                n_col       = w_col_start;
                n_row       = w_row_start;
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_WAIT_HIGH: begin
                        if (i_req.vsync_level) n_phase = PH_WAIT_LOW;
                    end
                    PH_WAIT_LOW: begin
                        if (!i_req.vsync_level) n_phase = PH_CAPTURE;
                    end
                    PH_CAPTURE: begin
                        // A falling pixel clock delivers one byte.
                        if (!i_req.pclk_level && r_prev_pclk) begin
                            if (r_second == i_cfg.capture_chroma) begin
                                n_pix_valid = 1'b1;
                                n_pix_value = i_req.pixel_byte;
                                n_pix_row   = r_row;
                                n_pix_col   = r_col;
                            end
                            if (r_second) begin
                                if (r_col == '0) begin
                                    if (r_row == '0) begin
                                        n_done  = 1'b1;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_row = r_row - ROW_W'(1);
                                        n_col = w_col_start;
                                    end
                                end else begin
                                    n_col = r_col - COL_W'(1);
                                end
                            end
                            n_second = !r_second;
                        end
                        n_prev_pclk = i_req.pclk_level;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
        n_busy = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_prev_pclk <= 1'b1;
            r_second    <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_prev_pclk <= n_prev_pclk;
            r_second    <= n_second;
            r_col       <= n_col;
            r_row       <= n_row;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix_valid <= n_pix_valid;
            r_pix_value <= n_pix_value;
            r_pix_row   <= n_pix_row;
            r_pix_col   <= n_pix_col;
            r_done      <= n_done;
            r_busy      <= n_busy;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.pixel_valid  = r_pix_valid;
    assign o_res.pixel_value  = r_pix_value;
    assign o_res.pixel_row    = r_pix_row;
    assign o_res.pixel_column = r_pix_col;
    assign o_res.frame_done   = r_done;
    assign o_res.capture_busy = r_busy;
endmodule

// File: hw/rtl/camera_parallel_frame_capture.sv
// Top level of the parallel camera frame capture block.
// Each result is registered: it appears in the result register in the cycle after its request is accepted.
// Throughput: one request per cycle unless the result side stalls; the edge detector and counters settle per request.
// The result register frees in the same cycle it is taken, so ready only drops on a stall.
// Reset (synchronous, active low) returns the sequencer to idle with the pixel clock history
// set high, clears the counters, and loads the registers with 0, 320 and 240.
module camera_parallel_frame_capture (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cpfc_in_if.sink                       i_req,
    cpfc_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpfc_pkg::APB_AW-1:0]   paddr,
    input  logic [cpfc_pkg::APB_DW-1:0]   pwdata,
    output logic [cpfc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import cpfc_pkg::*;

    // Current configuration, held in the register file. A write may land while a capture
    // is running: the byte selection applies from the next request, a new width from the
    // next line reload, and a new height only from the next arm request.
    t_cfg w_cfg;

    cpfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The core arms on a start request, waits for a full vertical sync pulse, then
    // takes one byte per falling pixel clock and keeps the selected byte of each pair.
    cpfc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (i_req),
        .o_res   (o_res)
    );
endmodule

// File: tb/capture_checker.sv
// Checker for the frame capture block: predicts each sample's result and compares it.
module capture_checker
    import cpfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cpfc_in_if                i_req_mon,
    cpfc_out_if               i_res_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic              pixel_valid;
        logic [BYTE_W-1:0] value;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic              done;
        logic              busy;
    } t_pixel_result;

    localparam int REPORT_LIMIT = 10;

    t_pixel_result    expected_pixels[$];
    t_cfg             shadow_cfg;
    t_phase           phase;
    logic             last_pclk;
    logic             on_second_byte;
    logic [COL_W-1:0] column_left;
    logic [ROW_W-1:0] row_left;
    int               mismatches;

    function automatic logic [COL_W-1:0] line_start_column();
        int unsigned w;
        w = 32'(shadow_cfg.frame_width);
        if (w < 1) w = 1;
        else if (w > MAX_COLUMNS) w = MAX_COLUMNS;
        return COL_W'(w - 1);
    endfunction

    function automatic logic [ROW_W-1:0] frame_start_row();
        int unsigned h;
        h = 32'(shadow_cfg.frame_height);
        if (h < 1) h = 1;
        else if (h > MAX_ROWS) h = MAX_ROWS;
        return ROW_W'(h - 1);
    endfunction

    // Advances the shadow sequencer by one request and gives the result it should produce.
    task automatic advance_capture(input logic cmd, input logic vs, input logic pc,
                                   input logic [BYTE_W-1:0] data, output t_pixel_result r);
        r = '0;
        if (cmd) begin
            phase          = PH_WAIT_HIGH;
            last_pclk      = 1'b1;
            on_second_byte = 1'b0;
            column_left    = line_start_column();
            row_left       = frame_start_row();
        end else begin
            case (phase)
                PH_WAIT_HIGH: begin
                    if (vs) phase = PH_WAIT_LOW;
                end
                PH_WAIT_LOW: begin
                    if (!vs) phase = PH_CAPTURE;
                end
                PH_CAPTURE: begin
                    if (!pc && last_pclk) begin
                        if (on_second_byte == shadow_cfg.capture_chroma) begin
                            r.pixel_valid = 1'b1;
                            r.value       = data;
                            r.row         = row_left;
                            r.column      = column_left;
                        end
                        if (on_second_byte) begin
                            if (column_left == '0) begin
                                if (row_left == '0) begin
                                    r.done = 1'b1;
                                    phase  = PH_IDLE;
                                end else begin
                                    row_left    = row_left - ROW_W'(1);
                                    column_left = line_start_column();
                                end
                            end else begin
                                column_left = column_left - COL_W'(1);
                            end
                        end
                        on_second_byte = ~on_second_byte;
                    end
                    last_pclk = pc;
                end
                default: ;
            endcase
        end
        r.busy = (phase != PH_IDLE);
    endtask

    always @(posedge i_clk) begin
        t_pixel_result got;
        t_pixel_result want;
        if (!i_rst_n) begin
            expected_pixels.delete();
            shadow_cfg.capture_chroma = 1'b0;
            shadow_cfg.frame_width    = COL_W'(320);
            shadow_cfg.frame_height   = ROW_W'(240);
            phase          = PH_IDLE;
            last_pclk      = 1'b1;
            on_second_byte = 1'b0;
            column_left    = '0;
            row_left       = '0;
            mismatches     = 0;
            o_fail_count   = 0;
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = '{i_res_mon.pixel_valid, i_res_mon.pixel_value, i_res_mon.pixel_row,
                        i_res_mon.pixel_column, i_res_mon.frame_done, i_res_mon.capture_busy};
                if (expected_pixels.size() == 0) begin
                    o_fail_count++;
                    if (mismatches < REPORT_LIMIT)
                        $display("checker: result with nothing outstanding: %p", got);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.pixel_valid !== want.pixel_valid || got.value !== want.value ||
                        got.row !== want.row || got.column !== want.column ||
                        got.done !== want.done || got.busy !== want.busy) begin
                        o_fail_count++;
                        if (mismatches < REPORT_LIMIT)
                            $display("checker: mismatch expected %p actual %p", want, got);
                        mismatches++;
                    end
                end
            end
            // A request taken at this edge still sees the configuration from before it.
            if (i_req_mon.valid && i_req_mon.ready) begin
                advance_capture(i_req_mon.command, i_req_mon.vsync_level,
                                i_req_mon.pclk_level, i_req_mon.pixel_byte, want);
                expected_pixels.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_CAPTURE_CHROMA: shadow_cfg.capture_chroma = pwdata[0];
                    REG_FRAME_WIDTH:    shadow_cfg.frame_width    = pwdata[COL_W-1:0];
                    REG_FRAME_HEIGHT:   shadow_cfg.frame_height   = pwdata[ROW_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the frame capture testbench: clock, reset, stimulus, configuration and verdict.
module testbench;
    import cpfc_pkg::*;

    // The run is cut short once this cycle limit is reached.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 400;
    // Register index three is not decoded by the block, so a write there must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cpfc_in_if  req_ch ();
    cpfc_out_if res_ch ();

    int fail_count;
    int pending;
    int cycle_count;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    // Effective frame size after clamping, used only to size the stimulus.
    int frame_pairs;
    int frame_lines;

    camera_parallel_frame_capture dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    capture_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_res_mon    (res_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("camera_parallel_frame_capture regression: fail");
        $finish;
    end

    // The result side takes results at random, with the stall rate set by the current mode.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request, after a random run of idle cycles, and holds it until it is taken.
    // Valid is left high on return, so back-to-back requests never see it dropped.
    task automatic push_request(input logic cmd, input logic vs, input logic pc,
                                input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.vsync_level <= vs;
        req_ch.pclk_level  <= pc;
        req_ch.pixel_byte  <= data;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // Stops sending and waits for every outstanding result, so that the block is quiet.
    task automatic wait_results_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // A two-phase APB write: setup with penable low, then the access phase until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes all three registers; the caller has already drained the result channel.
    task automatic set_capture(input int chroma, input int width, input int height);
        write_reg(REG_CAPTURE_CHROMA, chroma);
        write_reg(REG_FRAME_WIDTH, width);
        write_reg(REG_FRAME_HEIGHT, height);
        frame_pairs = (width % 1024 < 1) ? 1 : (width % 1024 > MAX_COLUMNS) ? MAX_COLUMNS
                                                                            : width % 1024;
        frame_lines = (height % 512 < 1) ? 1 : (height % 512 > MAX_ROWS) ? MAX_ROWS
                                                                         : height % 512;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Random pin samples, now and then an arm command among them.
    task automatic send_noise(input int count);
        repeat (count)
            push_request($urandom_range(99) < 10, 1'($urandom_range(1)),
                         1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // Arms a capture and walks the sync pin through its high and low phases. The sample on
    // which sync falls carries a random pixel clock, which must not yet deliver a byte.
    task automatic arm_and_sync();
        push_request(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     8'($urandom_range(255)));
        repeat ($urandom_range(0, 2))
            push_request(1'b0, 1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
        repeat ($urandom_range(1, 3))
            push_request(1'b0, 1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
        push_request(1'b0, 1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // Each byte needs the pixel clock high and then low; the first low sample carries it.
    // Straight after sync the clock history is high, so the first byte may come with no
    // high sample at all. The sync pin is left to wander during capture.
    task automatic stream_bytes(input int count);
        for (int b = 0; b < count; b++) begin
            repeat ((b == 0) ? $urandom_range(0, 2) : $urandom_range(1, 2))
                push_request(1'b0, 1'($urandom_range(1)), 1'b1, 8'($urandom_range(255)));
            push_request(1'b0, 1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)));
            if ($urandom_range(99) < 30)
                push_request(1'b0, 1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)));
        end
    endtask

    // One frame, sometimes cut short so that the next arm request restarts a busy capture.
    task automatic run_frame();
        int total_bytes;
        total_bytes = 2 * frame_pairs * frame_lines;
        if ($urandom_range(99) < 10) send_noise($urandom_range(1, 4));
        arm_and_sync();
        if ($urandom_range(99) < 15) stream_bytes($urandom_range(0, total_bytes - 1));
        else stream_bytes(total_bytes);
        if ($urandom_range(99) < 10) send_noise($urandom_range(1, 4));
    endtask

    initial begin
        int random_start;
        int done_random;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.command     = 1'b0;
        req_ch.vsync_level = 1'b0;
        req_ch.pclk_level  = 1'b1;
        req_ch.pixel_byte  = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        items_sent         = 0;
        frame_pairs        = 320;
        frame_lines        = 240;
        set_idling(12, 81);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a two-pair, one-line frame walked by hand through every phase.
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        set_capture(0, 2, 1);
        push_request(1'b0, 1'b1, 1'b1, 8'hFF);    // samples while idle are ignored
        push_request(1'b0, 1'b0, 1'b0, 8'h00);
        push_request(1'b1, 1'b1, 1'b0, 8'hFF);    // arm: the pin fields do not matter
        push_request(1'b0, 1'b0, 1'b0, 8'hAA);    // still waiting for sync high
        push_request(1'b0, 1'b1, 1'b1, 8'h11);
        push_request(1'b0, 1'b1, 1'b0, 8'h22);
        push_request(1'b0, 1'b0, 1'b0, 8'h33);    // sync falls: capture begins
        push_request(1'b0, 1'b0, 1'b0, 8'h00);    // clock already low gives a byte at once
        push_request(1'b0, 1'b0, 1'b0, 8'h44);    // no new falling edge
        push_request(1'b0, 1'b1, 1'b1, 8'h55);
        push_request(1'b0, 1'b0, 1'b0, 8'hFF);    // second byte of the pair is dropped
        push_request(1'b0, 1'b0, 1'b1, 8'h66);
        push_request(1'b0, 1'b1, 1'b0, 8'h80);
        push_request(1'b0, 1'b0, 1'b1, 8'h77);
        push_request(1'b1, 1'b0, 1'b1, 8'h00);    // arm while busy restarts the capture
        push_request(1'b0, 1'b1, 1'b1, 8'h01);
        push_request(1'b0, 1'b0, 1'b1, 8'h02);
        stream_bytes(4);                          // the last pair flags frame done
        wait_results_drained();
        set_capture(1, 1, 1);                     // keep the chroma byte instead
        arm_and_sync();
        stream_bytes(2);

        // Random part, in three idling modes. Every phase starts by holding requests back
        // until every outstanding result has arrived, then picks a fresh small frame.
        random_start = items_sent;
        done_random  = 0;
        while (done_random < RANDOM_ITEMS) begin
            if (done_random < RANDOM_ITEMS / 3) set_idling(12, 81);
            else if (done_random < 2 * RANDOM_ITEMS / 3) set_idling(81, 12);
            else set_idling(0, 0);
            wait_results_drained();
            set_capture($urandom_range(1),
                        ($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 12),
                        $urandom_range(1, 3));
            repeat ($urandom_range(1, 3)) run_frame();
            done_random = items_sent - random_start;
        end

        // Extremes: the start of the widest line and of the tallest column. Each capture is
        // left running and the next arm request restarts it.
        set_idling(0, 0);
        wait_results_drained();
        set_capture(1, MAX_COLUMNS, 1);
        arm_and_sync();
        stream_bytes(32);
        wait_results_drained();
        set_capture(0, 1, MAX_ROWS);
        arm_and_sync();
        stream_bytes(32);

        // Out-of-range sizes clamp to the maximum; this capture is left running, and the
        // next writes land while it is still busy, before a re-arm restarts it.
        wait_results_drained();
        set_capture(1, 1023, 511);
        arm_and_sync();
        stream_bytes(60);
        wait_results_drained();
        set_capture(0, 0, 0);                     // zero sizes clamp to one
        stream_bytes(4);
        arm_and_sync();
        stream_bytes(2);

        wait_results_drained();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("camera_parallel_frame_capture regression: pass");
        end else begin
            $display("camera_parallel_frame_capture regression: fail");
        end
        $finish;
    end

endmodule

// File: camera_parallel_frame_capture.f
hw/rtl/cpfc_pkg.sv
hw/rtl/cpfc_if.sv
hw/rtl/cpfc_regs.sv
hw/rtl/cpfc_core.sv
hw/rtl/camera_parallel_frame_capture.sv
tb/capture_checker.sv
tb/testbench.sv
